[rtl/core/uev_pkg.sv]
`default_nettype none

package uev_pkg;

  // Encoding select codes held in the configuration register.
  localparam logic [2:0] ENC_UTF8     = 3'd0;
  localparam logic [2:0] ENC_UTF16_BE = 3'd1;
  localparam logic [2:0] ENC_UTF16_LE = 3'd2;
  localparam logic [2:0] ENC_UTF32_BE = 3'd3;
  localparam logic [2:0] ENC_UTF32_LE = 3'd4;

  // Code point limits used by the UTF-32 check.
  localparam logic [15:0] CP_MAX_HIGH = 16'h0010;  // upper half of 0x10FFFF
  localparam logic [20:0] CP_SURR_TOP = 21'h00001B; // 0xD800..0xDFFF >> 11

  // Surrogate prefixes of a 16-bit unit (top six bits).
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;

  // Per-text stream state carried between bytes.
  typedef struct packed {
    logic [1:0]  byte_phase;
    logic [23:0] unit_bytes;
    logic [1:0]  continuations_left;
    logic        awaiting_low_half;
    logic        seen_error;
  } uev_state_t;

endpackage

`default_nettype wire

[rtl/core/uev_step.sv]
`default_nettype none

module uev_step import uev_pkg::*; (
  input  wire logic [2:0] enc_sel,
  input  wire uev_state_t state,
  input  wire logic [7:0] data_byte,
  output uev_state_t      state_next,
  output logic            text_ok
);

  logic        complete;
  logic [7:0]  first;
  logic [15:0] unit16;
  logic [31:0] cp;

  // Assemble the candidate 16-bit and 32-bit units for both byte orders.
  always_comb begin
    first = state.unit_bytes[7:0];
    if (enc_sel == ENC_UTF16_BE) begin
      unit16 = {first, data_byte};
    end else begin
      unit16 = {data_byte, first};
    end
    if (enc_sel == ENC_UTF32_BE) begin
      cp = {state.unit_bytes, data_byte};
    end else begin
      cp = {data_byte, state.unit_bytes[7:0], state.unit_bytes[15:8],
            state.unit_bytes[23:16]};
    end
  end

  // Advance the stream state by one byte in the selected encoding.
  always_comb begin
    state_next = state;
    complete   = 1'b0;
    unique case (enc_sel)
      ENC_UTF8: begin
        if (state.continuations_left != 2'd0) begin
          if (data_byte[7:6] != 2'b10) begin
            state_next.seen_error = 1'b1;
          end
          state_next.continuations_left = state.continuations_left - 2'd1;
        end else if (data_byte[7] == 1'b0) begin
          state_next.continuations_left = 2'd0;
        end else if (data_byte[7:5] == 3'b110) begin
          state_next.continuations_left = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          state_next.continuations_left = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          state_next.continuations_left = 2'd3;
        end else begin
          state_next.seen_error = 1'b1;
        end
        complete = (state_next.continuations_left == 2'd0);
      end
      ENC_UTF16_BE, ENC_UTF16_LE: begin
        if (state.byte_phase == 2'd0) begin
          state_next.unit_bytes = {16'h0000, data_byte};
          state_next.byte_phase = 2'd1;
        end else begin
          state_next.byte_phase = 2'd0;
          state_next.unit_bytes = '0;
          complete = 1'b1;
          if (state.awaiting_low_half) begin
            if (unit16[15:10] != SURR_LOW) begin
              state_next.seen_error = 1'b1;
            end
            state_next.awaiting_low_half = 1'b0;
          end else if (unit16[15:10] == SURR_HIGH) begin
            state_next.awaiting_low_half = 1'b1;
          end else if (unit16[15:10] == SURR_LOW) begin
            state_next.seen_error = 1'b1;
          end
        end
      end
      ENC_UTF32_BE, ENC_UTF32_LE: begin
        if (state.byte_phase != 2'd3) begin
          state_next.unit_bytes = {state.unit_bytes[15:0], data_byte};
          state_next.byte_phase = state.byte_phase + 2'd1;
        end else begin
          state_next.byte_phase = 2'd0;
          state_next.unit_bytes = '0;
          complete = 1'b1;
          if ((cp[31:16] > CP_MAX_HIGH) || (cp[31:11] == CP_SURR_TOP)) begin
            state_next.seen_error = 1'b1;
          end
        end
      end
      default: begin
        // Unused encoding codes: the text can never be valid.
        state_next.seen_error = 1'b1;
      end
    endcase
  end

  // Verdict if this byte closes the text.
  assign text_ok = complete && !state_next.seen_error && !state_next.awaiting_low_half;

endmodule

`default_nettype wire

[rtl/core/unicode_encoding_validator_unit.sv]
`default_nettype none

// A request carrying last passes the input register and then the result register to valid_res.
// Throughput: one byte per cycle but for the stall below; the stream state updates with each byte.
// An unread verdict stalls intake only when the next final byte needs the output.
// Reset (rst, synchronous) selects UTF-8 and clears the stream state and both stages.
// A configuration write also clears the stream state.
module unicode_encoding_validator_unit import uev_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            valid_res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] encoding
);

  logic       [2:0] enc_sel;
  uev_state_t       state;
  uev_state_t       state_next;
  logic             text_ok;
  logic             s1_valid;
  logic       [7:0] s1_byte;
  logic             s1_last;
  logic             s1_fire;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // The input stage drains unless it holds a final byte and the output is blocked.
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  uev_step u_step (
    .enc_sel    (enc_sel),
    .state      (state),
    .data_byte  (s1_byte),
    .state_next (state_next),
    .text_ok    (text_ok)
  );

  // Encoding register and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_sel <= ENC_UTF8;
      state   <= '0;
    end else if (cfg_fire) begin
      enc_sel <= encoding;
      state   <= '0;
    end else if (s1_fire) begin
      state <= s1_last ? '0 : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      valid_res <= text_ok;
    end
  end

  // UTF-8 continuation tracking only runs under UTF-8.
  assert property (@(posedge clk) disable iff (rst)
    (state.continuations_left != 2'd0) |-> (enc_sel == ENC_UTF8))
    else $error("continuation count set outside UTF-8");

  // A pending surrogate exists only under UTF-16.
  assert property (@(posedge clk) disable iff (rst)
    state.awaiting_low_half |-> (enc_sel == ENC_UTF16_BE || enc_sel == ENC_UTF16_LE))
    else $error("surrogate wait outside UTF-16");

  // UTF-16 never goes past the second byte of a unit.
  assert property (@(posedge clk) disable iff (rst)
    (enc_sel == ENC_UTF16_BE || enc_sel == ENC_UTF16_LE) |-> (state.byte_phase <= 2'd1))
    else $error("UTF-16 byte phase out of range");

  // The final byte of a text leaves a clean state and a pending verdict.
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (state == '0) && out_valid)
    else $error("end of text did not clear state or post a verdict");

  // A final byte never overwrites an unread verdict.
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |-> (!out_valid || out_ready))
    else $error("verdict overwritten");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uev_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int SEGMENT_BYTES = 39;

  // One byte request as it travels to the block.
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       valid_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] encoding = ENC_UTF8;

  unicode_encoding_validator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .encoding  (encoding)
  );

  always #2 clk = ~clk;

  // Requests waiting to be driven, the text being assembled, and the expected verdicts.
  byte_req_t  byte_q[$];
  logic [7:0] text_q[$];
  bit         verdict_q[$];

  int issued_cnt = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int bytes_built = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // Predictor state, a copy of what the block keeps per text.
  logic [2:0]  enc_sel;
  logic [1:0]  part_cnt;
  logic [23:0] part_bytes;
  logic [1:0]  cont_left;
  logic        low_pending;
  logic        text_bad;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic clear_text_state();
    part_cnt = '0;
    part_bytes = '0;
    cont_left = '0;
    low_pending = 1'b0;
    text_bad = 1'b0;
  endtask

  // Advances the predicted stream state by one byte and queues a verdict on the final byte.
  task automatic advance_validator(input logic [7:0] b, input logic lst);
    bit          complete;
    bit          big;
    logic [15:0] u;
    logic [31:0] cp;
    complete = 1'b0;
    big = (enc_sel == ENC_UTF16_BE) || (enc_sel == ENC_UTF32_BE);
    case (enc_sel)
      ENC_UTF8: begin
        if (cont_left != 2'd0) begin
          if ((b & 8'hC0) != 8'h80) text_bad = 1'b1;
          cont_left = cont_left - 2'd1;
        end else if (b < 8'h80) begin
          cont_left = 2'd0;
        end else if ((b & 8'hE0) == 8'hC0) begin
          cont_left = 2'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
          cont_left = 2'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
          cont_left = 2'd3;
        end else begin
          text_bad = 1'b1;
        end
        complete = (cont_left == 2'd0);
      end
      ENC_UTF16_BE, ENC_UTF16_LE: begin
        if (part_cnt == 2'd0) begin
          part_bytes = {16'h0000, b};
          part_cnt = 2'd1;
        end else begin
          u = big ? {part_bytes[7:0], b} : {b, part_bytes[7:0]};
          part_cnt = 2'd0;
          part_bytes = '0;
          if (low_pending) begin
            if (u < 16'hDC00 || u > 16'hDFFF) text_bad = 1'b1;
            low_pending = 1'b0;
          end else if (u >= 16'hD800 && u < 16'hDC00) begin
            low_pending = 1'b1;
          end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
            text_bad = 1'b1;
          end
          complete = 1'b1;
        end
      end
      ENC_UTF32_BE, ENC_UTF32_LE: begin
        if (part_cnt < 2'd3) begin
          part_bytes = {part_bytes[15:0], b};
          part_cnt = part_cnt + 2'd1;
        end else begin
          if (big) cp = {part_bytes, b};
          else cp = {b, part_bytes[7:0], part_bytes[15:8], part_bytes[23:16]};
          part_cnt = 2'd0;
          part_bytes = '0;
          if (cp > 32'h0010FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) text_bad = 1'b1;
          complete = 1'b1;
        end
      end
      default: begin
        text_bad = 1'b1;
      end
    endcase
    if (lst) begin
      verdict_q.push_back(complete && !text_bad && !low_pending);
      clear_text_state();
    end
  endtask

  // Monitor: tracks accepted requests and configuration writes, checks every verdict.
  always @(posedge clk) begin
    if (rst) begin
      enc_sel = ENC_UTF8;
      clear_text_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        enc_sel = encoding;
        clear_text_state();
      end
      if (in_valid && in_ready) begin
        accepted_cnt++;
        advance_validator(data_byte, last);
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %b with none expected", valid_res));
        end else if (valid_res !== verdict_q[0]) begin
          flag_mismatch($sformatf("valid_res %b, expected %b", valid_res, verdict_q[0]));
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  // Driver: holds a request until it is taken, then maybe idles before the next one.
  always @(negedge clk) begin
    byte_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accepted_cnt == issued_cnt) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        req = byte_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= req.b;
        last <= req.lst;
        issued_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Moves the assembled text (one random byte if empty) into the request queue, last flag on its final byte.
  task automatic send_text();
    int k;
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
    for (k = 0; k < text_q.size(); k++) begin
      byte_q.push_back('{b: text_q[k], lst: (k == text_q.size() - 1)});
    end
    bytes_built += text_q.size();
    text_q.delete();
  endtask

  task automatic send_bytes(input logic [7:0] bs[$]);
    text_q = bs;
    send_text();
  endtask

  // Waits until every request is taken and every verdict has come, then lets the block settle.
  task automatic wait_idle();
    while (byte_q.size() > 0 || accepted_cnt != issued_cnt || verdict_q.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_encoding(input logic [2:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    encoding <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] utf8_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Appends one UTF-8 character, or a malformed piece when flawed.
  task automatic add_utf8(input bit flawed);
    int k;
    int n;
    logic [7:0] b;
    if (flawed) begin
      case ($urandom_range(2))
        0: text_q.push_back(utf8_cont());
        1: text_q.push_back(8'hF8 | 8'($urandom_range(7)));
        default: begin
          text_q.push_back(8'hC0 | 8'($urandom_range(31)));
          b = 8'($urandom_range(255));
          if ((b & 8'hC0) == 8'h80) b = b ^ 8'h40;
          text_q.push_back(b);
        end
      endcase
    end else begin
      n = $urandom_range(3);
      case (n)
        0: text_q.push_back(8'($urandom_range(127)));
        1: text_q.push_back(8'hC0 | 8'($urandom_range(31)));
        2: text_q.push_back(8'hE0 | 8'($urandom_range(15)));
        default: text_q.push_back(8'hF0 | 8'($urandom_range(7)));
      endcase
      for (k = 0; k < n; k++) text_q.push_back(utf8_cont());
    end
  endtask

  task automatic put16(input logic [15:0] u, input bit big);
    if (big) begin
      text_q.push_back(u[15:8]);
      text_q.push_back(u[7:0]);
    end else begin
      text_q.push_back(u[7:0]);
      text_q.push_back(u[15:8]);
    end
  endtask

  function automatic logic [15:0] plain_unit();
    logic [15:0] u;
    u = 16'($urandom);
    if (u >= 16'hD800 && u <= 16'hDFFF) u = u ^ 16'h4000;
    return u;
  endfunction

  // Appends one UTF-16 character, or a broken surrogate arrangement when flawed.
  task automatic add_utf16(input bit big, input bit flawed);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = 16'hD800 | 16'($urandom_range(1023));
    lo = 16'hDC00 | 16'($urandom_range(1023));
    if (flawed) begin
      case ($urandom_range(2))
        0: put16(lo, big);
        1: begin
          put16(hi, big);
          put16(plain_unit(), big);
        end
        default: begin
          put16(hi, big);
          put16(16'hD800 | 16'($urandom_range(1023)), big);
        end
      endcase
    end else if ($urandom_range(99) < 30) begin
      put16(hi, big);
      put16(lo, big);
    end else begin
      put16(plain_unit(), big);
    end
  endtask

  task automatic put32(input logic [31:0] cp, input bit big);
    if (big) begin
      text_q.push_back(cp[31:24]);
      text_q.push_back(cp[23:16]);
      text_q.push_back(cp[15:8]);
      text_q.push_back(cp[7:0]);
    end else begin
      text_q.push_back(cp[7:0]);
      text_q.push_back(cp[15:8]);
      text_q.push_back(cp[23:16]);
      text_q.push_back(cp[31:24]);
    end
  endtask

  // Appends one UTF-32 value, out of range or a surrogate when flawed.
  task automatic add_utf32(input bit big, input bit flawed);
    logic [31:0] cp;
    if (flawed) begin
      if ($urandom_range(1) == 0) cp = 32'hD800 | 32'($urandom_range(2047));
      else cp = $urandom | 32'h0011_0000;
    end else begin
      case ($urandom_range(2))
        0: cp = 32'($urandom_range(127));
        1: cp = 32'($urandom_range(16'hFFFF));
        default: cp = 32'($urandom_range(32'h0010FFFF));
      endcase
      if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp ^ 32'h8000;
    end
    put32(cp, big);
  endtask

  // Builds one random text in the given encoding, mostly well formed.
  task automatic build_text(input logic [2:0] enc);
    int n;
    int k;
    int r;
    bit big;
    bit flawed;
    n = $urandom_range(1, 5);
    big = (enc == ENC_UTF16_BE) || (enc == ENC_UTF32_BE);
    for (k = 0; k < n; k++) begin
      flawed = ($urandom_range(99) < 10);
      case (enc)
        ENC_UTF8: add_utf8(flawed);
        ENC_UTF16_BE, ENC_UTF16_LE: add_utf16(big, flawed);
        ENC_UTF32_BE, ENC_UTF32_LE: add_utf32(big, flawed);
        default: text_q.push_back(8'($urandom_range(255)));
      endcase
    end
    // Now and then cut the final unit short or leave a stray byte at the end.
    r = $urandom_range(99);
    if (r < 6 && text_q.size() > 1) void'(text_q.pop_back());
    else if (r < 10) text_q.push_back(8'($urandom_range(255)));
    send_text();
  endtask

  // Stimulus sequence.
  initial begin
    logic [2:0] enc_order[8];
    logic [2:0] tmp;
    int ph;
    int s;
    int i;
    int j;
    int seg_start;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts in UTF-8 after reset: zero byte, bad lead, longest form, truncation.
    send_bytes('{8'h00});
    send_bytes('{8'hFF});
    send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    send_bytes('{8'hE2, 8'h82});

    // UTF-16 BE: surrogate pair, lone low surrogate, odd length.
    write_encoding(ENC_UTF16_BE);
    send_bytes('{8'hD8, 8'h00, 8'hDC, 8'h00});
    send_bytes('{8'hDC, 8'h00});
    send_bytes('{8'h41});

    // A register write in the middle of a text starts a fresh one.
    write_encoding(ENC_UTF16_LE);
    byte_q.push_back('{b: 8'h3D, lst: 1'b0});
    bytes_built++;
    write_encoding(ENC_UTF32_BE);
    send_bytes('{8'h00, 8'h10, 8'hFF, 8'hFF});

    // UTF-32 LE just above the top code point, then an unsupported encoding.
    write_encoding(ENC_UTF32_LE);
    send_bytes('{8'h00, 8'h00, 8'h11, 8'h00});
    write_encoding(3'd7);
    send_bytes('{8'h41});

    // Random phases: receiver-heavy idling, sender-heavy idling, then none.
    for (ph = 0; ph < 3; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          snd_idle_pct = 33;
          rcv_idle_pct = 59;
        end
        1: begin
          snd_idle_pct = 59;
          rcv_idle_pct = 33;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (i = 0; i < 8; i++) enc_order[i] = 3'(i);
      for (i = 7; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = enc_order[i];
        enc_order[i] = enc_order[j];
        enc_order[j] = tmp;
      end
      for (s = 0; s < 8; s++) begin
        write_encoding(enc_order[s]);
        seg_start = bytes_built;
        while (bytes_built - seg_start < SEGMENT_BYTES) build_text(enc_order[s]);
      end
    end

    // Let everything drain, then report.
    wait_idle();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[unicode_encoding_validator_unit.f]
rtl/core/uev_pkg.sv
rtl/core/uev_step.sv
rtl/core/unicode_encoding_validator_unit.sv
tb/sv/tb.sv
